/* hw/rtl/lrz_pkg.sv */
`timescale 1ns / 1ps

package lrz_pkg;

    localparam int COORD_W  = 10;
    localparam int INK_W    = 8;
    localparam int CHUNK_W  = 4;
    localparam int ADDR_W   = 20;
    localparam int SCREEN_W = 1024;
    localparam int CHUNK    = 64;

    localparam int PROD_W = 2 * COORD_W;
    localparam int DCNT_W = $clog2(PROD_W);
    localparam int CNT_W  = (CHUNK > 1) ? $clog2(CHUNK) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_RUN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic step;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic div_done;
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

/* hw/rtl/lrz_ctrl.sv */
`timescale 1ns / 1ps

module lrz_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lrz_pkg::t_dp_sts i_sts,
    output lrz_pkg::t_dp_cmd o_cmd
);
    import lrz_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = i_sts.empty ? S_IDLE : S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_sts.out_free && i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SETUP: begin
                o_cmd.mul = !i_sts.empty;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_RUN: begin
                o_cmd.step = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_done) |=> (r_state == S_DIV))
        else $error("division left early");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP && i_sts.empty) |=> (r_state == S_IDLE))
        else $error("empty chunk not dropped");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && i_sts.out_free && !i_sts.last) |=> (r_state == S_RUN))
        else $error("run ended before last pixel");

endmodule

/* hw/rtl/lrz_datapath.sv */
`timescale 1ns / 1ps

module lrz_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lrz_pkg::t_dp_cmd             i_cmd,
    output lrz_pkg::t_dp_sts             o_sts,
    input  logic [lrz_pkg::COORD_W-1:0]  i_start_x,
    input  logic [lrz_pkg::COORD_W-1:0]  i_start_y,
    input  logic [lrz_pkg::COORD_W-1:0]  i_end_x,
    input  logic [lrz_pkg::COORD_W-1:0]  i_end_y,
    input  logic [lrz_pkg::INK_W-1:0]    i_ink,
    input  logic [lrz_pkg::CHUNK_W-1:0]  i_chunk,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lrz_pkg::COORD_W-1:0]  o_pixel_x,
    output logic [lrz_pkg::COORD_W-1:0]  o_pixel_y,
    output logic [lrz_pkg::ADDR_W-1:0]   o_pixel_addr,
    output logic [lrz_pkg::INK_W-1:0]    o_pixel_ink,
    output logic                         o_chunk_last,
    output logic                         o_line_last
);
    import lrz_pkg::*;

    // line setup
    logic [COORD_W-1:0] r_x0, r_y0, r_y1, r_len, r_minor, r_i;
    logic               r_same, r_ymaj;
    logic [INK_W-1:0]   r_ink;
    logic [CNT_W-1:0]   r_cnt;
    // divider / DDA
    logic [PROD_W-1:0]  r_quo;
    logic [COORD_W-1:0] r_rem;
    logic [DCNT_W-1:0]  r_dcnt;
    // output word
    logic               r_out_valid;
    logic [COORD_W-1:0] r_px, r_py;
    logic [ADDR_W-1:0]  r_addr;
    logic [INK_W-1:0]   r_pink;
    logic               r_chunk_last, r_line_last;

    logic               swap_x, swap_y;
    logic [COORD_W-1:0] lx0, lx1, ly0, ly1, ldx, ldy;
    logic [31:0]        first;
    logic [COORD_W:0]   trial;
    logic               trial_ge;
    logic [COORD_W:0]   acc;
    logic               acc_ge;
    logic [COORD_W-1:0] q, q_ceil;
    logic [COORD_W-1:0] n_px, n_py;
    logic [ADDR_W-1:0]  n_addr;
    logic               is_line_last, is_last;

    always_comb begin
        swap_x = i_start_x > i_end_x;
        swap_y = i_start_y > i_end_y;
        lx0    = swap_x ? i_end_x : i_start_x;
        lx1    = swap_x ? i_start_x : i_end_x;
        ly0    = swap_y ? i_end_y : i_start_y;
        ly1    = swap_y ? i_start_y : i_end_y;
        ldx    = lx1 - lx0;
        ldy    = ly1 - ly0;
        first  = 32'(i_chunk) * 32'(CHUNK);
    end

    always_comb begin
        trial    = {r_rem, r_quo[PROD_W-1]};
        trial_ge = trial >= {1'b0, r_len};
        acc      = {1'b0, r_rem} + {1'b0, r_minor};
        acc_ge   = acc >= {1'b0, r_len};
        q        = r_quo[COORD_W-1:0];
        q_ceil   = q + COORD_W'(r_rem != '0);
    end

    always_comb begin
        if (r_ymaj) begin
            n_px = r_x0 + q;
            n_py = r_same ? (r_y0 + r_i) : (r_y1 - r_i);
        end else begin
            n_px = r_x0 + r_i;
            n_py = r_same ? (r_y0 + q) : (r_y1 - q_ceil);
        end
        n_addr       = ADDR_W'(32'(n_py) * 32'(SCREEN_W) + 32'(n_px));
        is_line_last = r_i == (r_len - COORD_W'(1));
        is_last      = is_line_last || (r_cnt == CNT_W'(CHUNK - 1));
    end

    always_comb begin
        o_sts.empty    = r_i >= r_len;
        o_sts.div_done = r_dcnt == DCNT_W'(PROD_W - 1);
        o_sts.last     = is_last;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0    <= lx0;
            r_y0    <= ly0;
            r_y1    <= ly1;
            r_same  <= swap_x == swap_y;
            r_ymaj  <= ldy > ldx;
            r_len   <= (ldy > ldx) ? ldy : ldx;
            r_minor <= (ldy > ldx) ? ldx : ldy;
            r_ink   <= i_ink;
            r_i     <= COORD_W'(first);
            r_cnt   <= '0;
        end
        if (i_cmd.mul) begin
            r_quo  <= PROD_W'(r_minor) * PROD_W'(r_i);
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= trial_ge ? COORD_W'(trial - {1'b0, r_len}) : trial[COORD_W-1:0];
            r_quo  <= {r_quo[PROD_W-2:0], trial_ge};
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
        if (i_cmd.step) begin
            r_px         <= n_px;
            r_py         <= n_py;
            r_addr       <= n_addr;
            r_pink       <= r_ink;
            r_chunk_last <= is_last;
            r_line_last  <= is_line_last;
            r_i          <= r_i + COORD_W'(1);
            r_cnt        <= r_cnt + CNT_W'(1);
            r_rem        <= acc_ge ? COORD_W'(acc - {1'b0, r_len}) : acc[COORD_W-1:0];
            r_quo        <= PROD_W'(q + COORD_W'(acc_ge));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_pixel_addr = r_addr;
    assign o_pixel_ink  = r_pink;
    assign o_chunk_last = r_chunk_last;
    assign o_line_last  = r_line_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_i < r_len))
        else $error("step past end of line");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_rem < r_len))
        else $error("remainder out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten");

endmodule

/* hw/rtl/line_pixel_rasterizer.sv */
`timescale 1ns / 1ps

// Line rasterizer: each input word gives two endpoints, a palette index and a
// chunk number, and yields up to CHUNK pixel words of that part of the line
// (far endpoint excluded, no clipping). An input is taken only while the
// block is idle. Per input: a setup state, then a bit-serial divider finds
// the minor-axis offset of the chunk's first step, then pixels follow one per
// cycle through an output register while that register is free to take them
// (up to 64 pixels). A chunk that lies past the end of the line, or a
// zero-length line, gives no pixel words.
module line_pixel_rasterizer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lrz_pkg::COORD_W-1:0]  i_start_x,
    input  logic [lrz_pkg::COORD_W-1:0]  i_start_y,
    input  logic [lrz_pkg::COORD_W-1:0]  i_end_x,
    input  logic [lrz_pkg::COORD_W-1:0]  i_end_y,
    input  logic [lrz_pkg::INK_W-1:0]    i_ink,
    input  logic [lrz_pkg::CHUNK_W-1:0]  i_chunk,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lrz_pkg::COORD_W-1:0]  o_pixel_x,
    output logic [lrz_pkg::COORD_W-1:0]  o_pixel_y,
    output logic [lrz_pkg::ADDR_W-1:0]   o_pixel_addr,
    output logic [lrz_pkg::INK_W-1:0]    o_pixel_ink,
    output logic                         o_chunk_last,
    output logic                         o_line_last
);
    import lrz_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    lrz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lrz_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_ink        (i_ink),
        .i_chunk      (i_chunk),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_pixel_addr (o_pixel_addr),
        .o_pixel_ink  (o_pixel_ink),
        .o_chunk_last (o_chunk_last),
        .o_line_last  (o_line_last)
    );

endmodule

/* verif/tb_line_pixel_rasterizer.sv */
`timescale 1ns / 1ps

module tb_line_pixel_rasterizer;
    import lrz_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic [INK_W-1:0]   ink;
        logic [CHUNK_W-1:0] chunk;
    } t_line_req;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ADDR_W-1:0]  addr;
        logic [INK_W-1:0]   ink;
        logic               chunk_end;
        logic               line_end;
    } t_pixel;

    // typed rows carry their expectation: none, or one pixel ending chunk and line
    typedef struct packed {
        t_line_req          req;
        logic               typed;
        logic               one_hit;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [ADDR_W-1:0]  addr;
    } t_dir_row;

    localparam int N_DIR  = 22;
    localparam int N_RAND = 300;

    t_dir_row dir_rows [N_DIR] = '{
        '{'{   5,   5,    5,   5,   0,  0}, 1, 0,    0,   0,      0},
        '{'{   0,   0,    1,   0,   0,  0}, 1, 1,    0,   0,      0},
        '{'{1023, 767, 1022, 767, 255,  0}, 1, 1, 1022, 767, 786430},
        '{'{1023,   0, 1023,   1, 170,  0}, 1, 1, 1023,   0,   1023},
        '{'{   0, 767,    0, 766,  85,  0}, 1, 1,    0, 767, 785408},
        '{'{   0,   0,   64,   0,  17,  1}, 1, 0,    0,   0,      0},
        '{'{   0,   0,   64,  10,  34,  0}, 0, 0,    0,   0,      0},
        '{'{   0,   0,   65,  30,  51,  1}, 0, 0,    0,   0,      0},
        '{'{   0,   0, 1023, 767, 255, 15}, 0, 0,    0,   0,      0},
        '{'{   0,   0, 1023, 767,   1,  0}, 0, 0,    0,   0,      0},
        '{'{1023,   0,    0, 767,   2,  3}, 0, 0,    0,   0,      0},
        '{'{   0, 767, 1023,   0,   4,  7}, 0, 0,    0,   0,      0},
        '{'{1023, 767,    0,   0,   8,  2}, 0, 0,    0,   0,      0},
        '{'{ 100,   0,  300, 767,  16,  5}, 0, 0,    0,   0,      0},
        '{'{ 300,   0,  100, 767,  32, 11}, 0, 0,    0,   0,      0},
        '{'{   0,   0,  700, 700,  64, 10}, 0, 0,    0,   0,      0},
        '{'{ 700,   0,    0, 700, 128,  0}, 0, 0,    0,   0,      0},
        '{'{  10,  20,  900,  20, 200, 13}, 0, 0,    0,   0,      0},
        '{'{ 512, 767,  512,   0, 100,  4}, 0, 0,    0,   0,      0},
        '{'{   3,   3,    8,   5, 170,  0}, 0, 0,    0,   0,      0},
        '{'{   8,   3,    3,   5,  85,  0}, 0, 0,    0,   0,      0},
        '{'{   0,   0, 1023,   0, 240, 15}, 0, 0,    0,   0,      0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [COORD_W-1:0] i_start_x;
    logic [COORD_W-1:0] i_start_y;
    logic [COORD_W-1:0] i_end_x;
    logic [COORD_W-1:0] i_end_y;
    logic [INK_W-1:0]   i_ink;
    logic [CHUNK_W-1:0] i_chunk;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [COORD_W-1:0] o_pixel_x;
    logic [COORD_W-1:0] o_pixel_y;
    logic [ADDR_W-1:0]  o_pixel_addr;
    logic [INK_W-1:0]   o_pixel_ink;
    logic               o_chunk_last;
    logic               o_line_last;

    t_pixel      pixels_due [$];
    t_pixel      due;
    int          fail_cnt = 0;
    bit          calm = 0;
    bit          squeeze = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;

    line_pixel_rasterizer i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("[line_pixel_rasterizer] ERROR");
        $finish;
    end

    // queue the pixel words of one chunk of the line, return how many
    function automatic int trace_line(input t_line_req r);
        logic [COORD_W-1:0] x0, x1, y0, y1;
        logic               flip_x, flip_y, same, steep;
        int unsigned        dx, dy, len, minor, first, stop, prod;
        t_pixel             p;
        flip_x = r.sx > r.ex;
        flip_y = r.sy > r.ey;
        x0 = flip_x ? r.ex : r.sx;
        x1 = flip_x ? r.sx : r.ex;
        y0 = flip_y ? r.ey : r.sy;
        y1 = flip_y ? r.sy : r.ey;
        same = (flip_x == flip_y);
        dx = x1 - x0;
        dy = y1 - y0;
        steep = dy > dx;
        len = steep ? dy : dx;
        minor = steep ? dx : dy;
        first = r.chunk * CHUNK;
        if (first >= len)
            return 0;
        stop = (first + CHUNK > len) ? len : first + CHUNK;
        for (int unsigned i = first; i < stop; i++) begin
            prod = minor * i;
            if (steep) begin
                p.x = COORD_W'(x0 + prod / len);
                p.y = COORD_W'(same ? y0 + i : y1 - i);
            end else begin
                p.x = COORD_W'(x0 + i);
                // falling x-major lines round the offset up
                p.y = COORD_W'(same ? y0 + prod / len : y1 - (prod + len - 1) / len);
            end
            p.addr = ADDR_W'(p.y * SCREEN_W + p.x);
            p.ink = r.ink;
            p.chunk_end = (i == stop - 1);
            p.line_end = (i == len - 1);
            pixels_due.push_back(p);
        end
        return stop - first;
    endfunction

    task automatic offer_line(input t_line_req r, input bit predict, output int n);
        n = 0;
        if (!calm && $urandom_range(1, 100) <= gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_x <= r.sx;
        i_start_y <= r.sy;
        i_end_x <= r.ex;
        i_end_y <= r.ey;
        i_ink <= r.ink;
        i_chunk <= r.chunk;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (predict)
            n = trace_line(r);
    endtask

    task automatic drain_all();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pixels_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pixels_due.size() == 0) begin
                $error("unexpected pixel word: x %0d y %0d", o_pixel_x, o_pixel_y);
                fail_cnt++;
            end else begin
                due = pixels_due.pop_front();
                check_field("pixel_x", due.x, o_pixel_x);
                check_field("pixel_y", due.y, o_pixel_y);
                check_field("pixel_addr", due.addr, o_pixel_addr);
                check_field("pixel_ink", due.ink, o_pixel_ink);
                check_field("chunk_last", due.chunk_end, o_chunk_last);
                check_field("line_last", due.line_end, o_line_last);
            end
        end
    end

    // output side: random stall bursts, one long hold-off on request
    initial begin
        bit held;
        int unsigned k;
        held = 0;
        forever begin
            if ($urandom_range(0, 99) == 0)
                stall_pct = $urandom_range(0, 2) * 25;
            if (squeeze && !held) begin
                held = 1;
                i_out_ready <= 1'b0;
                for (k = 0; k < 400; k++) @(posedge i_clk);
            end else if (!calm && $urandom_range(1, 100) <= stall_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        t_line_req   r;
        t_dir_row    row;
        int          n, made, tx, ty;
        int unsigned kind, len, d;
        bit          paused;
        made = 0;
        paused = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_start_x <= '0;
        i_start_y <= '0;
        i_end_x <= '0;
        i_end_y <= '0;
        i_ink <= '0;
        i_chunk <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIR; k++) begin
            row = dir_rows[k];
            offer_line(row.req, !row.typed, n);
            if (row.typed && row.one_hit)
                pixels_due.push_back(t_pixel'{row.px, row.py, row.addr, row.req.ink,
                                              1'b1, 1'b1});
        end
        drain_all();

        while (made < N_RAND) begin
            if ($urandom_range(0, 31) == 0)
                gap_pct = $urandom_range(0, 2) * 30;
            kind = $urandom_range(0, 9);
            r.ink = INK_W'($urandom_range(0, 255));
            r.sx = COORD_W'($urandom_range(0, 1023));
            r.sy = COORD_W'($urandom_range(0, 767));
            r.ex = COORD_W'($urandom_range(0, 1023));
            r.ey = COORD_W'($urandom_range(0, 767));
            r.chunk = '0;
            case (kind)
                5, 6: begin
                    tx = int'(r.sx) + int'($urandom_range(0, 80)) - 40;
                    ty = int'(r.sy) + int'($urandom_range(0, 80)) - 40;
                    r.ex = COORD_W'((tx < 0) ? 0 : (tx > 1023) ? 1023 : tx);
                    r.ey = COORD_W'((ty < 0) ? 0 : (ty > 767) ? 767 : ty);
                end
                7: begin
                    d = $urandom_range(1, 383);
                    r.ex = COORD_W'((r.sx + d <= 1023) ? r.sx + d : r.sx - d);
                    r.ey = COORD_W'((r.sy + d <= 767) ? r.sy + d : r.sy - d);
                    case ($urandom_range(0, 2))
                        0: r.ey = r.sy;
                        1: r.ex = r.sx;
                        default: ;
                    endcase
                end
                8: r.chunk = CHUNK_W'($urandom_range(0, 15));
                9: begin
                    if ($urandom_range(0, 1)) begin
                        r.ex = r.sx;
                        r.ey = r.sy;
                    end else begin
                        r.chunk = 15;
                    end
                end
                default: ;
            endcase
            if (kind <= 7) begin
                len = (r.sx > r.ex) ? r.sx - r.ex : r.ex - r.sx;
                d = (r.sy > r.ey) ? r.sy - r.ey : r.ey - r.sy;
                if (d > len)
                    len = d;
                if (len > 0)
                    r.chunk = CHUNK_W'($urandom_range(0, (len - 1) / CHUNK));
            end
            offer_line(r, 1'b1, n);
            if (n > 0)
                made++;
            if (made == 40)
                squeeze = 1;
            if (made >= 150 && !paused) begin
                paused = 1;
                drain_all();
            end
            if (made >= 270)
                calm = 1;
        end

        drain_all();
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("[line_pixel_rasterizer] OK");
        else
            $display("[line_pixel_rasterizer] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/lrz_pkg.sv
hw/rtl/lrz_ctrl.sv
hw/rtl/lrz_datapath.sv
hw/rtl/line_pixel_rasterizer.sv
verif/tb_line_pixel_rasterizer.sv
